/* src/crdp_pkg.sv */
// shared types, widths and helpers for the row dot product accumulator
// no dependencies
package crdp_pkg;

  localparam int RowW      = 4;
  localparam int ByteW     = 8;
  localparam int ProdW     = 2 * ByteW;
  localparam int SumW      = ProdW + 2;
  localparam int AccW      = 32;
  localparam int LaneMax   = 4;
  localparam int DefRows   = 16;
  localparam int DefLanes  = 4;
  localparam int InTdataW  = 72;
  localparam int OutTdataW = 40;

  typedef logic [ByteW-1:0] byte_t;
  typedef byte_t [LaneMax-1:0] lane_vec_t;
  typedef logic [LaneMax-1:0][ProdW-1:0] prod_vec_t;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic            first;
  } tag_t;

  // row modulo rows by restoring subtraction over the row bits
  function automatic int slot_of(logic [RowW-1:0] row, int rows);
    int r;
    r = int'(row);
    for (int j = RowW - 1; j >= 0; j--) begin
      if (r >= (rows << j)) begin
        r = r - (rows << j);
      end
    end
    return r;
  endfunction

endpackage

/* src/crdp_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
module crdp_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/crdp_mul.sv */
// first stage: one signed byte multiplier per lane, registered
// depends on crdp_pkg
module crdp_mul #(
  parameter int LANES = crdp_pkg::DefLanes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  crdp_pkg::tag_t      tag_i,
  input  crdp_pkg::lane_vec_t data_i,
  input  crdp_pkg::lane_vec_t weight_i,
  output logic                valid_o,
  output crdp_pkg::tag_t      tag_o,
  output crdp_pkg::prod_vec_t prod_o
);
  import crdp_pkg::*;

  logic      valid_q;
  tag_t      tag_q;
  prod_vec_t prod_d, prod_q;

  always_comb begin
    for (int l = 0; l < LaneMax; l++) begin
      if (l < LANES) begin
        prod_d[l] = ProdW'($signed(data_i[l]) * $signed(weight_i[l]));
      end else begin
        prod_d[l] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      tag_q  <= tag_i;
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign prod_o  = prod_q;

endmodule

/* src/crdp_sum.sv */
// second stage: adder tree over the lane products, registered
// depends on crdp_pkg
module crdp_sum (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  crdp_pkg::tag_t                tag_i,
  input  crdp_pkg::prod_vec_t           prod_i,
  output logic                          valid_o,
  output crdp_pkg::tag_t                tag_o,
  output logic [crdp_pkg::SumW-1:0]     sum_o
);
  import crdp_pkg::*;

  logic            valid_q;
  tag_t            tag_q;
  logic [SumW-1:0] pair0, pair1, sum_d, sum_q;

  always_comb begin
    pair0 = SumW'($signed(prod_i[0])) + SumW'($signed(prod_i[1]));
    pair1 = SumW'($signed(prod_i[2])) + SumW'($signed(prod_i[3]));
    sum_d = pair0 + pair1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      tag_q <= tag_i;
      sum_q <= sum_d;
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign sum_o   = sum_q;

endmodule

/* src/channel_accumulated_row_dot_product.sv */
// top level: lane multiply, adder tree and per row accumulate with output register
// depends on crdp_pkg, crdp_mul, crdp_sum and crdp_ram
//
// Each request carries one row of one channel: LANES signed byte pairs are
// multiplied, summed and added to that row's 32-bit accumulator, which the
// first-channel flag in tuser clears first. The result (row and new sum)
// leaves the output register, and a new request is taken every cycle unless
// the result side stalls: multiply, adder tree and accumulate are three register
// stages, and the accumulator store is a ram whose read is issued one stage
// early, with the value just written forwarded to a following request on the
// same row. Back pressure on the result side stalls only the stages that hold
// data. Rows at or above ROWS wrap onto entry row modulo ROWS; an entry read
// before any first-channel request has written it gives an arbitrary sum.
module channel_accumulated_row_dot_product #(
  parameter int ROWS  = crdp_pkg::DefRows,
  parameter int LANES = crdp_pkg::DefLanes
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // row[3:0], data_0..data_3, weight_0..weight_3 (8 bits each), zero pad
  input  logic [crdp_pkg::InTdataW-1:0]  s_axis_tdata,
  // first_channel
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_row[3:0], row_sum[35:4], zero pad
  output logic [crdp_pkg::OutTdataW-1:0] m_axis_tdata
);
  import crdp_pkg::*;

  localparam int SlotW = (ROWS > 1) ? $clog2(ROWS) : 1;

  tag_t            in_tag, tag1, tag2;
  lane_vec_t       in_data, in_weight;
  prod_vec_t       prod1;
  logic            v1, v2;
  logic [SumW-1:0] sum2;
  logic            en1, en2, en3;
  logic [SlotW-1:0] slot1, slot2;
  logic [AccW-1:0] rdata, base, acc;

  logic            fwd_d, fwd_q;
  logic [AccW-1:0] fwd_data_q;
  logic            out_valid_q;
  logic [RowW-1:0] out_row_q;
  logic [AccW-1:0] out_sum_q;

  always_comb begin
    in_tag.row   = s_axis_tdata[RowW-1:0];
    in_tag.first = s_axis_tuser;
    for (int l = 0; l < LaneMax; l++) begin
      in_data[l]   = s_axis_tdata[RowW + l*ByteW +: ByteW];
      in_weight[l] = s_axis_tdata[RowW + (LaneMax + l)*ByteW +: ByteW];
    end
  end

  assign en3 = !out_valid_q || m_axis_tready;
  assign en2 = en3 || !v2;
  assign en1 = en2 || !v1;
  assign s_axis_tready = en1;

  crdp_mul #(
    .LANES(LANES)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en1),
    .valid_i (s_axis_tvalid),
    .tag_i   (in_tag),
    .data_i  (in_data),
    .weight_i(in_weight),
    .valid_o (v1),
    .tag_o   (tag1),
    .prod_o  (prod1)
  );

  crdp_sum u_sum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en2),
    .valid_i(v1),
    .tag_i  (tag1),
    .prod_i (prod1),
    .valid_o(v2),
    .tag_o  (tag2),
    .sum_o  (sum2)
  );

  assign slot1 = SlotW'(slot_of(tag1.row, ROWS));
  assign slot2 = SlotW'(slot_of(tag2.row, ROWS));

  crdp_ram #(
    .Width(AccW),
    .Depth(ROWS)
  ) u_acc_ram (
    .clk_i  (clk_i),
    .we_i   (en3 && v2),
    .waddr_i(slot2),
    .wdata_i(acc),
    .re_i   (en2 && v1),
    .raddr_i(slot1),
    .rdata_o(rdata)
  );

  always_comb begin
    if (tag2.first) begin
      base = '0;
    end else if (fwd_q) begin
      base = fwd_data_q;
    end else begin
      base = rdata;
    end
    acc   = base + {{(AccW-SumW){sum2[SumW-1]}}, sum2};
    // the item in stage two writes on the same edge the next one reads
    fwd_d = v2 && en3 && (slot1 == slot2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en2) begin
        fwd_q <= fwd_d;
      end
      if (en3) begin
        out_valid_q <= v2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && fwd_d) begin
      fwd_data_q <= acc;
    end
    if (en3 && v2) begin
      out_row_q <= tag2.row;
      out_sum_q <= acc;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutTdataW-AccW-RowW){1'b0}}, out_sum_q, out_row_q};

endmodule

/* src/crdp_chk.sv */
// port level checker for the row dot product accumulator, bound to the top level
// depends on crdp_pkg and channel_accumulated_row_dot_product
module crdp_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [crdp_pkg::OutTdataW-1:0] m_axis_tdata
);

  logic       in_acc, out_acc;
  logic [2:0] cnt_d, cnt_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + 3'd1;
    end else if (!in_acc && out_acc) begin
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // no result without a request in flight
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_q != 3'd0)
    else $error("result without request");

  // three stages bound the requests in flight
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd3)
    else $error("too many requests in flight");

  // input stalls only under output back pressure
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without back pressure");

endmodule

bind channel_accumulated_row_dot_product crdp_chk u_crdp_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

/* bench/testbench.sv */
// self-checking bench for channel_accumulated_row_dot_product: directed extremes,
// a back to back run on one row, and random rows
// depends on crdp_pkg and the channel_accumulated_row_dot_product rtl
`timescale 1ns / 1ps

module testbench;

  localparam int NumRows    = 16;
  localparam int NumLanes   = 4;
  localparam int CycleLimit = 1_000_000;

  typedef struct {
    logic [3:0]      row;
    logic            first;
    logic [3:0][7:0] data;
    logic [3:0][7:0] weight;
    int              gap;
  } row_req_t;

  typedef struct {
    logic [3:0]  row;
    logic [31:0] sum;
  } row_sum_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [crdp_pkg::InTdataW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [crdp_pkg::OutTdataW-1:0] m_axis_tdata;

  row_req_t    req_q[$];
  row_req_t    on_bus;
  row_sum_t    row_sum_q[$];
  logic [31:0] acc_mirror[NumRows];
  bit          row_live[NumRows];
  int          gap_done = 0;
  int          stall_left = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int          errors = 0;
  int          cycle_count = 0;

  channel_accumulated_row_dot_product i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int pick_gap(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h80;
      1: return 8'h7f;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // signed byte lanes summed and added into the row accumulator, modulo 2^32
  function automatic void predict_row_sum(row_req_t r);
    logic signed [15:0] prod;
    logic [31:0]        lane_sum;
    row_sum_t           res;
    lane_sum = '0;
    for (int l = 0; l < NumLanes; l++) begin
      prod = $signed(r.data[l]) * $signed(r.weight[l]);
      lane_sum = lane_sum + {{16{prod[15]}}, prod};
    end
    if (r.first) begin
      acc_mirror[r.row] = '0;
    end
    acc_mirror[r.row] = acc_mirror[r.row] + lane_sum;
    res.row = r.row;
    res.sum = acc_mirror[r.row];
    row_sum_q.push_back(res);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  task automatic send_row(input logic [3:0] row, input logic first,
                          input logic [3:0][7:0] data, input logic [3:0][7:0] weight);
    row_req_t r;
    while (req_q.size() >= 2) begin
      @(posedge clk_i);
    end
    r.row    = row;
    r.first  = first || !row_live[row];
    r.data   = data;
    r.weight = weight;
    r.gap    = pick_gap(tx_idle_on);
    row_live[row] = 1'b1;
    req_q.push_back(r);
  endtask

  // sampled at the falling edge so the bus and queues have settled
  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (req_q.size() != 0 || s_axis_tvalid || row_sum_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // request side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_row_sum(on_bus);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_q.size() != 0 && gap_done >= req_q[0].gap) begin
          on_bus = req_q.pop_front();
          gap_done = 0;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0, on_bus.weight, on_bus.data, on_bus.row};
          s_axis_tuser  <= on_bus.first;
        end else begin
          gap_done = (req_q.size() == 0) ? 0 : gap_done + 1;
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          stall_left = pick_gap(rx_idle_on);
        end
      end
    end
  end

  // result check
  always @(posedge clk_i) begin
    row_sum_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (row_sum_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(m_axis_tdata[35:0]), '0);
      end else begin
        want = row_sum_q.pop_front();
        if (m_axis_tdata[3:0] !== want.row) begin
          report_mismatch("out_row", 32'(m_axis_tdata[3:0]), 32'(want.row));
        end
        if (m_axis_tdata[35:4] !== want.sum) begin
          report_mismatch("row_sum", m_axis_tdata[35:4], want.sum);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("channel_accumulated_row_dot_product verification failed");
      $finish;
    end
  end

  task automatic test_directed_extremes();
    logic [3:0][7:0] d;
    logic [3:0][7:0] w;
    for (int r = 0; r < NumRows; r++) begin
      case (r)
        0: begin
          d = {4{8'h80}};
          w = {4{8'h80}};
        end
        1: begin
          d = {4{8'h7f}};
          w = {4{8'h7f}};
        end
        2: begin
          d = '0;
          w = '0;
        end
        15: begin
          d = {4{8'h7f}};
          w = {4{8'h80}};
        end
        default: begin
          d = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
          w = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
        end
      endcase
      send_row(4'(r), 1'b1, d, w);
    end
    send_row(4'd0, 1'b0, {4{8'h80}}, {4{8'h80}});
    send_row(4'd15, 1'b0, {4{8'h7f}}, {4{8'h80}});
    send_row(4'd2, 1'b0, {8'hff, 8'h01, 8'h7f, 8'h80}, {8'h01, 8'hff, 8'h80, 8'h7f});
    send_row(4'd3, 1'b0, {8'h55, 8'haa, 8'h55, 8'haa}, {8'haa, 8'h55, 8'haa, 8'h55});
    send_row(4'd0, 1'b1, '0, {4{8'hff}});
    wait_drained();
  endtask

  // back to back on one row, each request building on the one before
  task automatic test_same_row_run();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_row(4'd9, 1'b1, {4{8'h80}}, {4{8'h80}});
    for (int i = 0; i < 64; i++) begin
      send_row(4'd9, 1'b0, {4{8'h80}}, {4{8'h80}});
    end
    wait_drained();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_random_rows(input int count);
    logic [3:0] row;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        wait_drained();
      end
      tx_idle_on = !(i >= (count * 3) / 4 && i < (count * 3) / 4 + 80);
      rx_idle_on = tx_idle_on;
      row = ($urandom_range(0, 9) < 4) ? 4'($urandom_range(0, 1)) : 4'($urandom_range(0, 15));
      send_row(row, $urandom_range(0, 7) == 0,
               {pick_byte(), pick_byte(), pick_byte(), pick_byte()},
               {pick_byte(), pick_byte(), pick_byte(), pick_byte()});
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_same_row_run();
    test_random_rows(600);
    repeat (8) @(posedge clk_i);
    if (row_sum_q.size() != 0) begin
      report_mismatch("results missing", 32'(row_sum_q.size()), '0);
    end
    if (errors == 0) begin
      $display("channel_accumulated_row_dot_product verification clean");
    end else begin
      $display("channel_accumulated_row_dot_product verification failed");
    end
    $finish;
  end

endmodule
